[sv/swm_pkg.sv]
// Shared types and codes for the min-tracking stack.
package swm_pkg;

  localparam int DataW = 32;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // input transaction taken this cycle
    logic load;    // registered memory read data is valid
  } swm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pop_deep;  // current input is a pop that exposes a stored entry
  } swm_sts_t;

endpackage

[sv/swm_ctrl.sv]
// Control state machine: handshakes and sequencing of pop refills.
module swm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  swm_pkg::swm_sts_t sts,
  output swm_pkg::swm_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_LOAD
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready   = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept     = in_valid && in_ready;
  assign cmd.accept = accept;
  assign cmd.load   = (state == S_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (sts.pop_deep) begin
              // result waits for the new top's minimum from memory
              state     <= S_LOAD;
              out_valid <= 1'b0;
            end else begin
              out_valid <= 1'b1;
            end
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_LOAD: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/swm_dp.sv]
// Datapath: stack memories, cached top entry, fill count and result registers.
module swm_dp #(
  parameter int DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  swm_pkg::swm_cmd_t                 cmd,
  output swm_pkg::swm_sts_t                 sts,
  input  logic [1:0]                        opcode,
  input  logic signed [swm_pkg::DataW-1:0]  push_value,
  output logic signed [swm_pkg::DataW-1:0]  top_value,
  output logic signed [swm_pkg::DataW-1:0]  min_value,
  output logic                              empty_flag,
  output logic [1:0]                        status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [swm_pkg::DataW-1:0] value_mem [DEPTH];
  logic signed [swm_pkg::DataW-1:0] min_mem   [DEPTH];

  logic [CW-1:0]                    count;
  logic signed [swm_pkg::DataW-1:0] top_val;
  logic signed [swm_pkg::DataW-1:0] top_min;
  logic signed [swm_pkg::DataW-1:0] rd_val;
  logic signed [swm_pkg::DataW-1:0] rd_min;

  logic                             empty;
  logic                             full;
  logic                             wr_en;
  logic [AW-1:0]                    wr_addr;
  logic [AW-1:0]                    rd_addr;
  logic                             rd_en;
  logic signed [swm_pkg::DataW-1:0] push_min;
  logic [CW-1:0]                    count_m2;

  assign empty    = (count == '0);
  assign full     = (count == CW'(DEPTH));
  assign count_m2 = count - CW'(2);
  assign wr_addr  = count[AW-1:0];
  assign rd_addr  = count_m2[AW-1:0];
  assign wr_en    = cmd.accept && (opcode == swm_pkg::OP_PUSH) && !full;
  assign sts.pop_deep = (opcode == swm_pkg::OP_POP) && (count > CW'(1));
  assign rd_en    = cmd.accept && sts.pop_deep;
  assign push_min = (!empty && (top_min < push_value)) ? top_min : push_value;

  // stack memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      value_mem[wr_addr] <= push_value;
      min_mem[wr_addr]   <= push_min;
    end
    if (rd_en) begin
      rd_val <= value_mem[rd_addr];
      rd_min <= min_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.accept) begin
      if (wr_en) begin
        count <= count + CW'(1);
      end else if ((opcode == swm_pkg::OP_POP) && !empty) begin
        count <= count - CW'(1);
      end
    end
  end

  // cached top entry and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      top_val   <= rd_val;
      top_min   <= rd_min;
      min_value <= rd_min;
    end else if (cmd.accept) begin
      priority if (opcode == swm_pkg::OP_PUSH) begin
        empty_flag <= 1'b0;
        if (full) begin
          top_value <= top_val;
          min_value <= top_min;
          status    <= swm_pkg::ST_FULL;
        end else begin
          top_val   <= push_value;
          top_min   <= push_min;
          top_value <= push_value;
          min_value <= push_min;
          status    <= swm_pkg::ST_OK;
        end
      end else if (empty) begin
        // pop or query with nothing stored
        top_value  <= '0;
        min_value  <= '0;
        empty_flag <= 1'b1;
        status     <= swm_pkg::ST_EMPTY;
      end else if (opcode == swm_pkg::OP_POP) begin
        top_value <= top_val;
        status    <= swm_pkg::ST_OK;
        if (count == CW'(1)) begin
          min_value  <= '0;
          empty_flag <= 1'b1;
        end else begin
          empty_flag <= 1'b0;  // min arrives on the refill cycle
        end
      end else begin
        top_value  <= top_val;
        min_value  <= top_min;
        empty_flag <= 1'b0;
        status     <= swm_pkg::ST_OK;
      end
    end
  end

endmodule

[sv/stack_with_min_core.sv]
// Bounded signed stack that reports its minimum on every transaction.
//
// Input channel (in_valid/in_ready): opcode 0 push push_value, 1 pop,
// 2 or 3 query top and minimum. Output channel (out_valid/out_ready):
// one result per input transaction with top_value, min_value, empty_flag
// and status (0 ok, 1 pop or query on empty, 2 push on full, dropped).
// Each stack level stores its value and the running minimum of itself
// and the levels below it; the top level is also cached in registers.
// Results for push, query and a pop that leaves the stack empty are
// registered from the accepted transaction; a pop that leaves values
// behind waits in the S_LOAD state, since the new top is fetched
// through the registered memory read. One transaction is in flight at
// a time. A new transaction can be taken in the cycle the previous
// result is taken, or whenever no result or refill is pending.
// If the receiver stalls, the result holds on the output and the input
// channel stays not ready until it is taken.
// Reset empties the stack (fill count to zero) and clears out_valid;
// no clearing pass over the memories is needed.
module stack_with_min_core #(
  parameter int DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        opcode,
  input  logic signed [swm_pkg::DataW-1:0]  push_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [swm_pkg::DataW-1:0]  top_value,
  output logic signed [swm_pkg::DataW-1:0]  min_value,
  output logic                              empty_flag,
  output logic [1:0]                        status
);

  swm_pkg::swm_cmd_t cmd;
  swm_pkg::swm_sts_t sts;

  swm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  swm_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .opcode     (opcode),
    .push_value (push_value),
    .top_value  (top_value),
    .min_value  (min_value),
    .empty_flag (empty_flag),
    .status     (status)
  );

endmodule

[verif/stack_with_min_core_tb.sv]
// Self-checking testbench for the min-tracking stack core.
module stack_with_min_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StackDepth = 256;
  localparam int IdleLimit = 2000;
  localparam int ItemCount = 570;
  localparam logic [1:0] OP_SPARE = 2'd3;  // unused code, acts as a query

  typedef struct {
    logic signed [swm_pkg::DataW-1:0] top;
    logic signed [swm_pkg::DataW-1:0] minv;
    logic                             empty;
    logic [1:0]                       status;
  } stack_result_t;

  class stack_min_tracker;
    logic signed [swm_pkg::DataW-1:0] level_value[StackDepth];
    logic signed [swm_pkg::DataW-1:0] level_min[StackDepth];
    int                               level;
    stack_result_t                    expected_results[$];
    int                               mismatches;

    function new();
      level = 0;
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    function void note_op(logic [1:0] op, logic signed [swm_pkg::DataW-1:0] val);
      stack_result_t r;
      r.top = '0;
      r.status = swm_pkg::ST_OK;
      case (op)
        swm_pkg::OP_PUSH: begin
          if (level == StackDepth) begin
            r.status = swm_pkg::ST_FULL;
            r.top = level_value[level-1];
          end else begin
            level_value[level] = val;
            level_min[level] = (level > 0 && level_min[level-1] < val) ?
                               level_min[level-1] : val;
            level++;
            r.top = val;
          end
        end
        swm_pkg::OP_POP: begin
          if (level == 0) begin
            r.status = swm_pkg::ST_EMPTY;
          end else begin
            level--;
            r.top = level_value[level];
          end
        end
        default: begin
          if (level == 0) r.status = swm_pkg::ST_EMPTY;
          else r.top = level_value[level-1];
        end
      endcase
      r.minv = (level == 0) ? '0 : level_min[level-1];
      r.empty = (level == 0);
      expected_results.push_back(r);
    endfunction

    task check_result(logic signed [swm_pkg::DataW-1:0] top,
                      logic signed [swm_pkg::DataW-1:0] minv,
                      logic empty, logic [1:0] status);
      stack_result_t e;
      if (expected_results.size() == 0) begin
        report("result with no transaction outstanding");
      end else begin
        e = expected_results.pop_front();
        if (top !== e.top)
          report($sformatf("top_value %0d, expected %0d", top, e.top));
        if (minv !== e.minv)
          report($sformatf("min_value %0d, expected %0d", minv, e.minv));
        if (empty !== e.empty)
          report($sformatf("empty_flag %0b, expected %0b", empty, e.empty));
        if (status !== e.status)
          report($sformatf("status %0d, expected %0d", status, e.status));
      end
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [1:0]                       opcode = swm_pkg::OP_PUSH;
  logic signed [swm_pkg::DataW-1:0] push_value = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [swm_pkg::DataW-1:0] top_value;
  logic signed [swm_pkg::DataW-1:0] min_value;
  logic                             empty_flag;
  logic [1:0]                       status;

  stack_min_tracker sb = new();
  bit quiet = 1'b0;
  int ready_hold = 0;
  int idle_cycles = 0;
  int sent = 0;

  stack_with_min_core #(.DEPTH(StackDepth)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .push_value(push_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .top_value(top_value), .min_value(min_value),
    .empty_flag(empty_flag), .status(status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [swm_pkg::DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3, 4: return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  task send_op(logic [1:0] op, logic signed [swm_pkg::DataW-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      opcode <= 2'($urandom);
      push_value <= $urandom;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    push_value <= val;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // biased op: push with probability push_pct, otherwise pop or a query code
  task send_biased(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) send_op(swm_pkg::OP_PUSH, pick_value());
    else if (r < push_pct + (100 - push_pct) * 3 / 4) send_op(swm_pkg::OP_POP, pick_value());
    else if ($urandom_range(0, 3) == 0) send_op(OP_SPARE, pick_value());
    else send_op(swm_pkg::OP_QUERY, pick_value());
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else begin
      ready_hold = pick_gap();
      out_ready <= (ready_hold == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_op(opcode, push_value);
      if (out_valid && out_ready) sb.check_result(top_value, min_value, empty_flag, status);
    end
  end

  // watchdog: no transaction on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty stack, extremes, equal minimums, spare opcode
    send_op(swm_pkg::OP_POP, 32'sd5);
    send_op(swm_pkg::OP_QUERY, 32'sd0);
    send_op(OP_SPARE, -32'sd1);
    send_op(swm_pkg::OP_PUSH, 32'sh8000_0000);
    send_op(swm_pkg::OP_QUERY, 32'sd0);
    send_op(swm_pkg::OP_PUSH, 32'sh7fff_ffff);
    send_op(OP_SPARE, 32'sd0);
    send_op(swm_pkg::OP_POP, 32'sd0);
    send_op(swm_pkg::OP_POP, 32'sd0);
    send_op(swm_pkg::OP_POP, 32'sd0);
    send_op(swm_pkg::OP_PUSH, 32'sd0);
    send_op(swm_pkg::OP_PUSH, -32'sd1);
    send_op(swm_pkg::OP_PUSH, 32'sd5);
    send_op(swm_pkg::OP_PUSH, -32'sd1);
    send_op(swm_pkg::OP_POP, 32'sd0);
    send_op(swm_pkg::OP_QUERY, 32'sd0);
    send_op(swm_pkg::OP_POP, 32'sd0);
    send_op(swm_pkg::OP_POP, 32'sd0);
    send_op(swm_pkg::OP_POP, 32'sd0);
    send_op(swm_pkg::OP_PUSH, 32'sh7fff_ffff);
    send_op(swm_pkg::OP_PUSH, 32'sh8000_0000);
    send_op(swm_pkg::OP_POP, 32'sd0);
    send_op(swm_pkg::OP_POP, 32'sd0);
    send_op(swm_pkg::OP_QUERY, 32'sd0);

    // fill to full, then hit the full case a few times
    while (sb.level < StackDepth) send_op(swm_pkg::OP_PUSH, pick_value());
    repeat (4) send_biased(70);
    quiet = 1'b1;
    repeat (10) send_biased(50);
    quiet = 1'b0;
    // drain to empty, then poke the empty case
    while (sb.level > 0) send_op(swm_pkg::OP_POP, pick_value());
    repeat (5) send_biased(30);
    // mixed traffic at shallow depth, with quiet stretches
    while (sent < ItemCount) begin
      if (sent % 8 == 0) quiet = ($urandom_range(0, 2) == 0);
      send_biased(50);
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.expected_results.size() != 0) sb.report("results still outstanding at end");
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
